[rtl/hdm_pkg.sv]
`timescale 1ns / 1ps
// shared types, widths and constants of the harmonic distortion meter
// no dependencies; imported by every module of the block
package hdm_pkg;

  // frame geometry
  localparam int BIN_COUNT = 512;
  localparam int BIN_IDX_W = $clog2(BIN_COUNT + 1);
  // window compare width: holds 5 * 127 + 2 and the bin index plus 2
  localparam int CMP_W     = ((BIN_IDX_W > 10) ? BIN_IDX_W : 10) + 1;
  localparam int HARM_MAX  = 5;
  localparam int WIN_HALF  = 2;

  // datapath widths
  localparam int SMP_W     = 16;
  localparam int PWR_W     = 32;
  localparam int FSUM_W    = 35;
  localparam int HSUM_W    = 37;
  localparam int RSUM_W    = 27;
  localparam int THD_W     = 24;
  localparam int INT_BITS  = 16;
  localparam int FRAC_BITS = 32;
  localparam int QUO_W     = INT_BITS + FRAC_BITS;
  localparam int SAT_W     = FSUM_W + INT_BITS;
  localparam int ROOT_ITERS = QUO_W / 2;
  localparam int ITER_W    = $clog2(QUO_W + 1);
  localparam int FCNT_W    = 3;
  localparam int FPR_W     = 4;
  localparam int FBIN_W    = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [THD_W-1:0] THD_SAT = '1;
  localparam logic [FPR_W-1:0] FPR_MAX = FPR_W'(8);

  // configuration reset values
  localparam logic [PWR_W-1:0]  THRESHOLD_RST = PWR_W'(25);
  localparam logic [FBIN_W-1:0] FBIN_RST      = FBIN_W'(80);
  localparam logic [FPR_W-1:0]  FPR_RST       = FPR_W'(3);

  // frame queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POWER_THRESHOLD   = 2'd0,
    CFG_FUNDAMENTAL_BIN   = 2'd1,
    CFG_FRAMES_PER_REPORT = 2'd2
  } cfg_index_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_ROOT,
    BK_ACCUM,
    BK_REPORT
  } back_state_e;

  typedef struct packed {
    logic [HSUM_W-1:0] h;
    logic [FSUM_W-1:0] f;
  } frame_t;

  typedef struct packed {
    logic   valid;
    frame_t frame;
  } frame_push_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
  } queue_status_t;

endpackage

[rtl/hdm_front.sv]
`timescale 1ns / 1ps
// front part: bin power, window classification and per-frame power sums
// depends on hdm_pkg; pushes finished frame sums into hdm_frame_queue
module hdm_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic signed [hdm_pkg::SMP_W-1:0] bin_real_i,
  input  logic signed [hdm_pkg::SMP_W-1:0] bin_imag_i,
  input  logic                          last_bin_i,
  input  logic [hdm_pkg::PWR_W-1:0]     power_threshold_i,
  input  logic [hdm_pkg::FBIN_W-1:0]    fundamental_bin_i,
  input  hdm_pkg::queue_status_t        qstat_i,
  output hdm_pkg::frame_push_t          push_o
);
  import hdm_pkg::*;

  logic                 accept;
  logic [BIN_IDX_W-1:0] idx_q;
  logic                 in_range;
  logic [HARM_MAX-1:0]  hit;
  logic [2:0]           hcnt;

  // stage 0: registered bin and its window class
  logic                    v0_q, last0_q, use0_q, fund0_q;
  logic [2:0]              hc0_q;
  logic signed [SMP_W-1:0] re0_q, im0_q;
  // stage 1: squares
  logic                    v1_q, last1_q, use1_q, fund1_q;
  logic [2:0]              hc1_q;
  logic [PWR_W-1:0]        sqr1_q, sqi1_q;
  logic signed [PWR_W-1:0] sq_re, sq_im;
  // stage 2: thresholded power
  logic                    v2_q, last2_q, fund2_q;
  logic [2:0]              hc2_q;
  logic [PWR_W-1:0]        p2_q, pwr;
  // sums
  logic [FSUM_W-1:0]       fsum_q, fsum_n, fadd;
  logic [HSUM_W-1:0]       hsum_q, hsum_n, hadd;
  logic [QCNT_W:0]         inflight, credit;

  assign accept   = push_i & ~full_o;
  assign in_range = idx_q < BIN_IDX_W'(BIN_COUNT);

  // window hits around f, 2f .. 5f
  always_comb begin
    logic [CMP_W-1:0] pos;
    logic [CMP_W-1:0] hf;
    pos = CMP_W'(idx_q);
    for (int h = 1; h <= HARM_MAX; h++) begin
      hf = CMP_W'(fundamental_bin_i) * CMP_W'(h);
      hit[h-1] = (pos + CMP_W'(WIN_HALF) >= hf) && (pos <= hf + CMP_W'(WIN_HALF));
    end
  end

  assign hcnt = 3'(hit[1]) + 3'(hit[2]) + 3'(hit[3]) + 3'(hit[4]);

  // bin index within the frame, held at the bin count until last bin
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (accept) begin
      if (last_bin_i) begin
        idx_q <= '0;
      end else if (in_range) begin
        idx_q <= idx_q + BIN_IDX_W'(1);
      end
    end
  end

  // pipeline valid and end-of-frame flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      last0_q <= 1'b0;
      last1_q <= 1'b0;
      last2_q <= 1'b0;
    end else begin
      v0_q    <= accept;
      v1_q    <= v0_q;
      v2_q    <= v1_q;
      last0_q <= accept & last_bin_i;
      last1_q <= v0_q & last0_q;
      last2_q <= v1_q & last1_q;
    end
  end

  assign sq_re = re0_q * re0_q;
  assign sq_im = im0_q * im0_q;
  assign pwr   = sqr1_q + sqi1_q;

  // pipeline payload
  always_ff @(posedge clk_i) begin
    re0_q   <= bin_real_i;
    im0_q   <= bin_imag_i;
    use0_q  <= in_range;
    fund0_q <= hit[0];
    hc0_q   <= hcnt;
    sqr1_q  <= unsigned'(sq_re);
    sqi1_q  <= unsigned'(sq_im);
    use1_q  <= use0_q;
    fund1_q <= fund0_q;
    hc1_q   <= hc0_q;
    p2_q    <= (use1_q && (pwr > power_threshold_i)) ? pwr : '0;
    fund2_q <= fund1_q;
    hc2_q   <= hc1_q;
  end

  // accumulate window powers
  assign fadd   = fund2_q ? FSUM_W'(p2_q) : '0;
  assign hadd   = HSUM_W'(p2_q) * HSUM_W'(hc2_q);
  assign fsum_n = fsum_q + fadd;
  assign hsum_n = hsum_q + hadd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsum_q <= '0;
      hsum_q <= '0;
    end else if (v2_q) begin
      if (last2_q) begin
        fsum_q <= '0;
        hsum_q <= '0;
      end else begin
        fsum_q <= fsum_n;
        hsum_q <= hsum_n;
      end
    end
  end

  assign push_o.valid   = v2_q & last2_q;
  assign push_o.frame.h = hsum_n;
  assign push_o.frame.f = fsum_n;

  // hold off new bins while every queue slot is spoken for
  assign inflight = (QCNT_W+1)'(last0_q) + (QCNT_W+1)'(last1_q) + (QCNT_W+1)'(last2_q);
  assign credit   = (QCNT_W+1)'(qstat_i.count) + inflight;
  assign full_o   = credit >= (QCNT_W+1)'(QDEPTH);

endmodule

[rtl/hdm_frame_queue.sv]
`timescale 1ns / 1ps
// short queue of frame power sums between front and back parts
// depends on hdm_pkg
module hdm_frame_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  hdm_pkg::frame_push_t   push_i,
  input  logic                   pop_i,
  output hdm_pkg::frame_t        frame_o,
  output hdm_pkg::queue_status_t status_o
);
  import hdm_pkg::*;

  frame_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] count_q;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_q] <= push_i.frame;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i.valid) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      if (push_i.valid && !pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (!push_i.valid && pop_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  assign frame_o        = mem_q[rd_q];
  assign status_o.count = count_q;
  assign status_o.empty = (count_q == '0);

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> (count_q < QCNT_W'(QDEPTH)) || pop_i)
    else $error("frame queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("frame queue read while empty");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH))
    else $error("frame queue level out of range");
`endif

endmodule

[rtl/hdm_back.sv]
`timescale 1ns / 1ps
// back part: per-frame ratio divide and square root, frame averaging, result register
// depends on hdm_pkg; takes frames from hdm_frame_queue
module hdm_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  hdm_pkg::frame_t            frame_i,
  input  hdm_pkg::queue_status_t     qstat_i,
  output logic                       frame_pop_o,
  input  logic [hdm_pkg::FPR_W-1:0]  frames_per_report_i,
  output logic                       empty_o,
  input  logic                       pop_i,
  output logic [hdm_pkg::THD_W-1:0]  thd_average_o,
  output logic                       no_fundamental_o
);
  import hdm_pkg::*;

  back_state_e       state_q, state_d;
  logic [FSUM_W-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [QUO_W-1:0]  dvd_q, dvd_d, root_q, root_d, bit_q, bit_d;
  logic [ITER_W-1:0] cnt_q, cnt_d;
  logic              avg_mode_q, avg_mode_d;
  logic [THD_W-1:0]  thd_q, thd_d;
  logic              zero_q, zero_d;
  logic [RSUM_W-1:0] rsum_q, rsum_d;
  logic [FCNT_W-1:0] fcnt_q, fcnt_d;
  logic              fault_q, fault_d, rfault_q, rfault_d;
  logic              res_valid_q, res_valid_d, res_nf_q, res_nf_d;
  logic [THD_W-1:0]  res_thd_q, res_thd_d;

  logic              frame_zero, frame_sat;
  logic [FSUM_W:0]   rem_sh;
  logic              div_ge;
  logic [FSUM_W-1:0] div_rem;
  logic [QUO_W-1:0]  rt_try, rt_root;
  logic              rt_ge;
  logic [FPR_W-1:0]  n_frames;
  logic [RSUM_W-1:0] sum_new;
  logic [FCNT_W:0]   cnt_new;
  logic              report;

  // frame classification
  assign frame_zero = (frame_i.f == '0);
  assign frame_sat  = SAT_W'(frame_i.h) >= SAT_W'({frame_i.f, INT_BITS'(0)});

  // one restoring divide step
  assign rem_sh  = {rem_q, dvd_q[QUO_W-1]};
  assign div_ge  = rem_sh >= {1'b0, dvs_q};
  assign div_rem = div_ge ? FSUM_W'(rem_sh - {1'b0, dvs_q}) : FSUM_W'(rem_sh);

  // one square root step, radicand kept in the divider quotient register
  assign rt_try  = root_q + bit_q;
  assign rt_ge   = dvd_q >= rt_try;
  assign rt_root = rt_ge ? ((root_q >> 1) + bit_q) : (root_q >> 1);

  // frame averaging bookkeeping
  assign n_frames = (frames_per_report_i == '0) ? FPR_W'(1) :
                    (frames_per_report_i > FPR_MAX) ? FPR_MAX : frames_per_report_i;
  assign sum_new  = rsum_q + RSUM_W'(thd_q);
  assign cnt_new  = {1'b0, fcnt_q} + (FCNT_W+1)'(1);
  assign report   = cnt_new >= (FCNT_W+1)'(n_frames);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!qstat_i.empty) begin
          state_d = (frame_zero || frame_sat) ? BK_ACCUM : BK_DIVIDE;
        end
      end
      BK_DIVIDE: begin
        if (cnt_q == ITER_W'(1)) begin
          state_d = avg_mode_q ? BK_REPORT : BK_ROOT;
        end
      end
      BK_ROOT: begin
        if (cnt_q == ITER_W'(1)) begin
          state_d = BK_ACCUM;
        end
      end
      BK_ACCUM: begin
        state_d = report ? BK_DIVIDE : BK_IDLE;
      end
      BK_REPORT: begin
        if (!res_valid_q) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // datapath and outputs per state
  always_comb begin
    frame_pop_o = 1'b0;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    dvd_d       = dvd_q;
    root_d      = root_q;
    bit_d       = bit_q;
    cnt_d       = cnt_q;
    avg_mode_d  = avg_mode_q;
    thd_d       = thd_q;
    zero_d      = zero_q;
    rsum_d      = rsum_q;
    fcnt_d      = fcnt_q;
    fault_d     = fault_q;
    rfault_d    = rfault_q;
    res_valid_d = res_valid_q;
    res_thd_d   = res_thd_q;
    res_nf_d    = res_nf_q;

    // result taken by the consumer
    if (pop_i && res_valid_q) begin
      res_valid_d = 1'b0;
    end

    unique case (state_q)
      BK_IDLE: begin
        if (!qstat_i.empty) begin
          frame_pop_o = 1'b1;
          zero_d      = frame_zero;
          thd_d       = THD_SAT;
          rem_d       = FSUM_W'(frame_i.h >> INT_BITS);
          dvd_d       = QUO_W'({frame_i.h[INT_BITS-1:0], FRAC_BITS'(0)});
          dvs_d       = frame_i.f;
          cnt_d       = ITER_W'(QUO_W);
          avg_mode_d  = 1'b0;
        end
      end
      BK_DIVIDE: begin
        rem_d = div_rem;
        dvd_d = {dvd_q[QUO_W-2:0], div_ge};
        cnt_d = cnt_q - ITER_W'(1);
        if (cnt_q == ITER_W'(1) && !avg_mode_q) begin
          root_d = '0;
          bit_d  = QUO_W'(1) << (QUO_W - 2);
          cnt_d  = ITER_W'(ROOT_ITERS);
        end
      end
      BK_ROOT: begin
        if (rt_ge) begin
          dvd_d = dvd_q - rt_try;
        end
        root_d = rt_root;
        bit_d  = bit_q >> 2;
        cnt_d  = cnt_q - ITER_W'(1);
        if (cnt_q == ITER_W'(1)) begin
          thd_d = THD_W'(rt_root);
        end
      end
      BK_ACCUM: begin
        if (report) begin
          dvd_d      = QUO_W'({sum_new, (QUO_W-RSUM_W)'(0)});
          rem_d      = '0;
          dvs_d      = FSUM_W'(n_frames);
          cnt_d      = ITER_W'(RSUM_W);
          avg_mode_d = 1'b1;
          rfault_d   = fault_q | zero_q;
          rsum_d     = '0;
          fcnt_d     = '0;
          fault_d    = 1'b0;
        end else begin
          rsum_d  = sum_new;
          fcnt_d  = cnt_new[FCNT_W-1:0];
          fault_d = fault_q | zero_q;
        end
      end
      BK_REPORT: begin
        if (!res_valid_q) begin
          res_valid_d = 1'b1;
          res_thd_d   = (dvd_q[RSUM_W-1:0] > RSUM_W'(THD_SAT)) ? THD_SAT
                                                                : THD_W'(dvd_q[RSUM_W-1:0]);
          res_nf_d    = rfault_q;
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      avg_mode_q  <= 1'b0;
      rsum_q      <= '0;
      fcnt_q      <= '0;
      fault_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      avg_mode_q  <= avg_mode_d;
      rsum_q      <= rsum_d;
      fcnt_q      <= fcnt_d;
      fault_q     <= fault_d;
      res_valid_q <= res_valid_d;
    end
  end

  // arithmetic payload
  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    dvs_q     <= dvs_d;
    dvd_q     <= dvd_d;
    root_q    <= root_d;
    bit_q     <= bit_d;
    thd_q     <= thd_d;
    zero_q    <= zero_d;
    rfault_q  <= rfault_d;
    res_thd_q <= res_thd_d;
    res_nf_q  <= res_nf_d;
  end

  assign empty_o          = ~res_valid_q;
  assign thd_average_o    = res_thd_q;
  assign no_fundamental_o = res_nf_q;

`ifndef SYNTHESIS
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DIVIDE) |-> (dvs_q != '0))
    else $error("divide started with zero divisor");
  a_root_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_ROOT) |-> $onehot(bit_q))
    else $error("square root step bit lost");
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(state_q == BK_REPORT))
    else $error("result register loaded outside report");
`endif

endmodule

[rtl/harmonic_distortion_meter.sv]
`timescale 1ns / 1ps
// top level of the harmonic distortion meter: configuration registers and part wiring
// depends on hdm_pkg, hdm_front, hdm_frame_queue and hdm_back
//
//  channel  handshake              payload
//  bins     push_i / full_o        bin_real_i, bin_imag_i, last_bin_i
//  results  empty_o / pop_i        thd_average_o, no_fundamental_o
//  config   cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// the front takes one bin per cycle while full_o is low; its three-stage power
// pipeline lies between the bin inputs and the four-entry frame queue
// the back loads each frame, runs 48 divide and 24 root steps and accumulates, plus
// 27 divide steps and a result load on a report; full_o rises while four frames are
// queued or in the pipeline, so short frames wait on the back's divide and root
// reset clears all control state at once; there is no clearing pass
module harmonic_distortion_meter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push_i,
  output logic                               full_o,
  input  logic signed [hdm_pkg::SMP_W-1:0]   bin_real_i,
  input  logic signed [hdm_pkg::SMP_W-1:0]   bin_imag_i,
  input  logic                               last_bin_i,
  output logic                               empty_o,
  input  logic                               pop_i,
  output logic [hdm_pkg::THD_W-1:0]          thd_average_o,
  output logic                               no_fundamental_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [hdm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [hdm_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import hdm_pkg::*;

  logic [PWR_W-1:0]  threshold_q;
  logic [FBIN_W-1:0] fbin_q;
  logic [FPR_W-1:0]  fpr_q;
  frame_push_t       push;
  frame_t            head;
  queue_status_t     qstat;
  logic              frame_pop;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RST;
      fbin_q      <= FBIN_RST;
      fpr_q       <= FPR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_POWER_THRESHOLD:   threshold_q <= cfg_data_i[PWR_W-1:0];
        CFG_FUNDAMENTAL_BIN:   fbin_q      <= cfg_data_i[FBIN_W-1:0];
        CFG_FRAMES_PER_REPORT: fpr_q       <= cfg_data_i[FPR_W-1:0];
        default: ;
      endcase
    end
  end

  // bin intake and frame sums
  hdm_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push_i),
    .full_o            (full_o),
    .bin_real_i        (bin_real_i),
    .bin_imag_i        (bin_imag_i),
    .last_bin_i        (last_bin_i),
    .power_threshold_i (threshold_q),
    .fundamental_bin_i (fbin_q),
    .qstat_i           (qstat),
    .push_o            (push)
  );

  // frames waiting for the back part
  hdm_frame_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pop_i    (frame_pop),
    .frame_o  (head),
    .status_o (qstat)
  );

  // ratio, root and averaging
  hdm_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .frame_i             (head),
    .qstat_i             (qstat),
    .frame_pop_o         (frame_pop),
    .frames_per_report_i (fpr_q),
    .empty_o             (empty_o),
    .pop_i               (pop_i),
    .thd_average_o       (thd_average_o),
    .no_fundamental_o    (no_fundamental_o)
  );

endmodule

[tb/harmonic_distortion_meter_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for harmonic_distortion_meter: directed table, then random frames
// depends on hdm_pkg and the harmonic_distortion_meter rtl
module harmonic_distortion_meter_tb;
  import hdm_pkg::*;

  localparam int RANDOM_ITEMS   = 1850;
  localparam int REPORTS_WANTED = 36;
  // room for the back to drain four queued frames plus the pipeline
  localparam int SETTLE_CYCLES  = 800;
  localparam int HOLD_CYCLES    = 1500;
  localparam int TIMEOUT_NS     = 20_000_000;

  typedef struct packed {
    logic [THD_W-1:0] thd;
    logic             fault;
  } thd_report_t;

  typedef enum logic {ROW_BIN, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    cfg_index_e              reg_idx;
    logic [CFG_DATA_W-1:0]   value;
    logic signed [SMP_W-1:0] re;
    logic signed [SMP_W-1:0] im;
    logic                    last;
    logic                    typed;
    logic [THD_W-1:0]        thd;
    logic                    fault;
  } table_row_t;

  function automatic table_row_t bin_row(logic signed [SMP_W-1:0] re, im, logic last);
    return '{ROW_BIN, CFG_POWER_THRESHOLD, '0, re, im, last, 1'b0, '0, 1'b0};
  endfunction

  function automatic table_row_t chk_row(logic signed [SMP_W-1:0] re, im, logic last,
                                         logic [THD_W-1:0] thd, logic fault);
    return '{ROW_BIN, CFG_POWER_THRESHOLD, '0, re, im, last, 1'b1, thd, fault};
  endfunction

  function automatic table_row_t cfg_row(cfg_index_e idx, logic [CFG_DATA_W-1:0] value);
    return '{ROW_CFG, idx, value, '0, '0, 1'b0, 1'b0, '0, 1'b0};
  endfunction

  // directed stimulus, expected values typed where obvious
  localparam table_row_t STIM_TABLE [23] = '{
    // reset settings: three one-bin frames, no fundamental anywhere
    bin_row(16'sh0000, 16'sh0000, 1'b1),
    bin_row(16'sh7FFF, 16'sh7FFF, 1'b1),
    chk_row(16'sh8000, 16'sh8000, 1'b1, 24'hFFFFFF, 1'b1),
    cfg_row(CFG_POWER_THRESHOLD, 32'd0),
    cfg_row(CFG_FUNDAMENTAL_BIN, 32'd3),
    cfg_row(CFG_FRAMES_PER_REPORT, 32'd1),
    // lone fundamental, no harmonic power
    bin_row(16'sh0000, 16'sh0000, 1'b0),
    chk_row(16'sh8000, 16'sh8000, 1'b1, 24'h000000, 1'b0),
    // bin 4 sits in the fundamental and second harmonic windows
    bin_row(16'sh0000, 16'sh0000, 1'b0),
    bin_row(16'sh0001, 16'sh0000, 1'b0),
    bin_row(16'sh0000, 16'sh0000, 1'b0),
    bin_row(16'sh0000, 16'sh0000, 1'b0),
    bin_row(16'sh7FFF, 16'sh8000, 1'b1),
    // same overlap alone: ratio of exactly one
    bin_row(16'sh0000, 16'sh0000, 1'b0),
    bin_row(16'sh0000, 16'sh0000, 1'b0),
    bin_row(16'sh0000, 16'sh0000, 1'b0),
    bin_row(16'sh0000, 16'sh0000, 1'b0),
    chk_row(16'sh8000, 16'sh8000, 1'b1, 24'h010000, 1'b0),
    // power equal to the threshold is not counted
    cfg_row(CFG_POWER_THRESHOLD, 32'd25),
    bin_row(16'sh0000, 16'sh0000, 1'b0),
    chk_row(16'sh0003, 16'sh0004, 1'b1, 24'hFFFFFF, 1'b1),
    // fundamental at bin 0: bins 0..2 count once as fundamental, four times as harmonic
    cfg_row(CFG_FUNDAMENTAL_BIN, 32'd0),
    chk_row(16'sh8000, 16'sh0000, 1'b1, 24'h020000, 1'b0)
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  push_i;
  logic                  full_o;
  logic signed [SMP_W-1:0] bin_real_i;
  logic signed [SMP_W-1:0] bin_imag_i;
  logic                  last_bin_i;
  logic                  empty_o;
  logic                  pop_i;
  logic [THD_W-1:0]      thd_average_o;
  logic                  no_fundamental_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  harmonic_distortion_meter uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push_i),
    .full_o           (full_o),
    .bin_real_i       (bin_real_i),
    .bin_imag_i       (bin_imag_i),
    .last_bin_i       (last_bin_i),
    .empty_o          (empty_o),
    .pop_i            (pop_i),
    .thd_average_o    (thd_average_o),
    .no_fundamental_o (no_fundamental_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // predictor copy of the configuration and frame state
  logic [PWR_W-1:0]  thr_cfg  = THRESHOLD_RST;
  logic [FBIN_W-1:0] fbin_cfg = FBIN_RST;
  logic [FPR_W-1:0]  fpr_cfg  = FPR_RST;
  int                bin_pos     = 0;
  logic [63:0]       fund_power  = '0;
  logic [63:0]       harm_power  = '0;
  logic [31:0]       thd_sum     = '0;
  int                frames_done = 0;
  logic              fault_flag  = 1'b0;

  thd_report_t reports_due[$];
  int          reports_total = 0;
  int          bins_sent     = 0;
  int          errors        = 0;
  int          send_idle_pct = 8;
  int          recv_idle_pct = 79;
  bit          hold_request  = 1'b0;

  // floor(sqrt(h * 2^32 / f)) in Q8.16, saturated
  function automatic logic [THD_W-1:0] thd_of_frame(logic [63:0] h, logic [63:0] f);
    logic [95:0]      scaled;
    logic [47:0]      quot;
    logic [47:0]      sq;
    logic [THD_W-1:0] root;
    logic [THD_W-1:0] trial;
    if (f == 0) return THD_SAT;
    if (h / f >= 64'd65536) return THD_SAT;
    scaled = {h, 32'b0} / {32'b0, f};
    quot = scaled[47:0];
    root = '0;
    for (int b = THD_W - 1; b >= 0; b--) begin
      trial = root | (24'd1 << b);
      sq = trial * trial;
      if (sq <= quot) root = trial;
    end
    return root;
  endfunction

  // advance the predictor by one accepted bin
  task automatic meter_step(input logic signed [SMP_W-1:0] re, im, input logic last,
                            output logic made, output thd_report_t rpt);
    longint      p;
    int          d;
    int          n;
    logic [31:0] avg;
    made = 1'b0;
    rpt = '0;
    if (bin_pos < BIN_COUNT) begin
      p = longint'(re) * longint'(re) + longint'(im) * longint'(im);
      if (p > longint'({32'b0, thr_cfg})) begin
        for (int h = 1; h <= HARM_MAX; h++) begin
          d = bin_pos - h * int'(fbin_cfg);
          if (d >= -WIN_HALF && d <= WIN_HALF) begin
            if (h == 1) fund_power += 64'(p);
            else harm_power += 64'(p);
          end
        end
      end
      bin_pos++;
    end
    if (last) begin
      if (fund_power == 0) fault_flag = 1'b1;
      thd_sum += {8'b0, thd_of_frame(harm_power, fund_power)};
      frames_done++;
      bin_pos = 0;
      fund_power = '0;
      harm_power = '0;
      n = (fpr_cfg == 0) ? 1 : (fpr_cfg > FPR_MAX) ? int'(FPR_MAX) : int'(fpr_cfg);
      if (frames_done >= n) begin
        avg = thd_sum / 32'(n);
        if (avg > {8'b0, THD_SAT}) avg = {8'b0, THD_SAT};
        rpt.thd = avg[THD_W-1:0];
        rpt.fault = fault_flag;
        made = 1'b1;
        thd_sum = '0;
        frames_done = 0;
        fault_flag = 1'b0;
      end
    end
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random pop, one long hold-off on request
  initial begin : result_drain
    pop_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        pop_i <= 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) @(negedge clk_i);
      end else begin
        pop_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // compare each popped result with the oldest expectation
  always @(posedge clk_i) begin : result_check
    thd_report_t want;
    if (rst_ni && pop_i && !empty_o) begin
      if (reports_due.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected nothing,",  $time);
        $display("  got thd_average %06h no_fundamental %b", thd_average_o, no_fundamental_o);
      end else begin
        want = reports_due.pop_front();
        if (thd_average_o !== want.thd) begin
          errors++;
          $display("%0t: thd_average expected %06h, got %06h", $time, want.thd, thd_average_o);
        end
        if (no_fundamental_o !== want.fault) begin
          errors++;
          $display("%0t: no_fundamental expected %b, got %b", $time, want.fault,
                   no_fundamental_o);
        end
      end
    end
  end

  // offer one bin, called and returning at a falling edge; push stays high
  task automatic offer_bin(input logic signed [SMP_W-1:0] re, im, input logic last,
                           output logic made, output thd_report_t rpt);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push_i <= 1'b0;
      @(negedge clk_i);
    end
    push_i     <= 1'b1;
    bin_real_i <= re;
    bin_imag_i <= im;
    last_bin_i <= last;
    do @(posedge clk_i); while (full_o);
    meter_step(re, im, last, made, rpt);
    @(negedge clk_i);
  endtask

  // register write, predictor follows on acceptance
  task automatic write_reg(input cfg_index_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_POWER_THRESHOLD:   thr_cfg = data;
      CFG_FUNDAMENTAL_BIN:   fbin_cfg = data[FBIN_W-1:0];
      CFG_FRAMES_PER_REPORT: fpr_cfg = data[FPR_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // wait for all expected results, then let the back finish silent frames
  task automatic settle();
    while (reports_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic signed [SMP_W-1:0] signed_part(int lo, int hi);
    int v;
    v = $urandom_range(lo, hi);
    return SMP_W'($urandom_range(0, 1) ? -v : v);
  endfunction

  // one frame: strong fundamental, weaker harmonics, low noise, some raw words
  task automatic send_frame(input int len, input bit fund_off);
    logic signed [SMP_W-1:0] re;
    logic signed [SMP_W-1:0] im;
    logic                    made;
    thd_report_t             rpt;
    bit                      in_fund;
    bit                      in_harm;
    int                      f;
    f = int'(fbin_cfg);
    for (int i = 0; i < len; i++) begin
      in_fund = (i - f >= -WIN_HALF) && (i - f <= WIN_HALF);
      in_harm = 1'b0;
      for (int h = 2; h <= HARM_MAX; h++)
        if (i - h * f >= -WIN_HALF && i - h * f <= WIN_HALF) in_harm = 1'b1;
      if (fund_off && in_fund) begin
        re = '0;
        im = '0;
      end else if ($urandom_range(0, 9) == 0) begin
        re = SMP_W'($urandom);
        im = SMP_W'($urandom);
      end else if (in_fund) begin
        re = signed_part(4000, 32767);
        im = signed_part(0, 32767);
      end else if (in_harm) begin
        re = signed_part(0, 1 << $urandom_range(2, 14));
        im = signed_part(0, 1 << $urandom_range(2, 14));
      end else begin
        re = signed_part(0, 6);
        im = signed_part(0, 6);
      end
      offer_bin(re, im, i == len - 1, made, rpt);
      bins_sent++;
      if (made) begin
        reports_due.push_back(rpt);
        reports_total++;
      end
    end
  endtask

  // main sequence
  initial begin : stimulus
    table_row_t            row;
    logic                  made;
    thd_report_t           rpt;
    int                    phase_no;
    int                    nframes;
    int                    fixed_len;
    int                    len;
    logic [CFG_DATA_W-1:0] thr_w;
    logic [CFG_DATA_W-1:0] fbin_w;
    logic [CFG_DATA_W-1:0] fpr_w;

    rst_ni      = 1'b0;
    push_i      = 1'b0;
    bin_real_i  = '0;
    bin_imag_i  = '0;
    last_bin_i  = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_POWER_THRESHOLD;
    cfg_data_i  = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table
    foreach (STIM_TABLE[k]) begin
      row = STIM_TABLE[k];
      if (row.kind == ROW_CFG) begin
        push_i <= 1'b0;
        settle();
        write_reg(row.reg_idx, row.value);
      end else begin
        offer_bin(row.re, row.im, row.last, made, rpt);
        if (row.typed) begin
          reports_due.push_back('{row.thd, row.fault});
          reports_total++;
        end else if (made) begin
          reports_due.push_back(rpt);
          reports_total++;
        end
      end
    end
    push_i <= 1'b0;

    // random phases, each with its own settings
    bins_sent = 0;
    phase_no = 0;
    while (bins_sent < RANDOM_ITEMS || reports_total < REPORTS_WANTED) begin
      settle();
      fixed_len = 0;
      thr_w = $urandom_range(0, 400);
      fbin_w = $urandom_range(3, 8);
      fpr_w = $urandom_range(1, 2);
      nframes = $urandom_range(2, 8);
      case (phase_no)
        0: begin
          thr_w = 32'hFFFF_FFFF;
          fpr_w = 1;
          nframes = 3;
        end
        1: begin
          thr_w = 32'h7FFF_FFFF;
          fbin_w = 3;
          fpr_w = 15;
          nframes = 9;
        end
        2: begin
          // highest legal fundamental, frame runs past the bin count
          fbin_w = 101;
          fpr_w = 0;
          nframes = 1;
          fixed_len = BIN_COUNT + 3;
        end
        3: begin
          fbin_w = 127;
          fpr_w = 1;
          nframes = 1;
          fixed_len = 130;
        end
        4: begin
          fbin_w = $urandom_range(0, 2);
          fpr_w = $urandom_range(1, 3);
          nframes = 6;
        end
        5: begin
          thr_w = 25;
          fbin_w = 3;
          fpr_w = 1;
          nframes = 12;
        end
        default: begin
          case ($urandom_range(0, 9))
            0: thr_w = 0;
            1: thr_w = $urandom;
            2: thr_w = $urandom_range(0, 1 << 20);
            default: ;
          endcase
          if ($urandom_range(0, 9) == 0) fbin_w = $urandom_range(0, 2);
          else fbin_w = $urandom_range(3, 8);
          if ($urandom_range(0, 4) == 0) fpr_w = $urandom_range(0, 15);
          // stray upper bits on the narrow registers
          if ($urandom_range(0, 9) < 3) fbin_w |= $urandom & ~32'h7F;
          if ($urandom_range(0, 9) < 3) fpr_w |= $urandom & ~32'hF;
        end
      endcase
      write_reg(CFG_POWER_THRESHOLD, thr_w);
      write_reg(CFG_FUNDAMENTAL_BIN, fbin_w);
      write_reg(CFG_FRAMES_PER_REPORT, fpr_w);

      // sender idles lightly first, then the receiver does, then neither
      if (bins_sent < RANDOM_ITEMS / 3) begin
        send_idle_pct = 8;
        recv_idle_pct = 79;
      end else if (bins_sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 79;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (phase_no == 5) hold_request = 1'b1;

      for (int fr = 0; fr < nframes; fr++) begin
        if (fixed_len != 0) len = fixed_len;
        else if ($urandom_range(0, 4) == 0) len = $urandom_range(1, 5 * fbin_cfg + 3);
        else len = 5 * fbin_cfg + 3 + $urandom_range(0, 6);
        send_frame(len, $urandom_range(0, 19) == 0);
      end
      push_i <= 1'b0;
      phase_no++;
    end

    settle();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
